// ===== src/orbit_position_spherical_to_cartesian_top_macros.svh =====
// assertion macros shared by the checker
`ifndef ORBIT_POSITION_SPHERICAL_TO_CARTESIAN_TOP_MACROS_SVH
`define ORBIT_POSITION_SPHERICAL_TO_CARTESIAN_TOP_MACROS_SVH

// implication that must hold every clock outside reset
`define OPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked on the next clock
`define OPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ops2c_pkg.sv =====
// ---------------------------------------------------------------------------
// ops2c_pkg
// Types and constants for the orbit eye position converter.
// ---------------------------------------------------------------------------
package ops2c_pkg;

  typedef struct packed {
    logic [16:0]        progress;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
  } out_t;

  localparam int unsigned CfgIdxBits = 3;
  localparam logic [2:0] REG_RADIUS_START  = 3'd0;
  localparam logic [2:0] REG_RADIUS_DELTA  = 3'd1;
  localparam logic [2:0] REG_ZENITH_START  = 3'd2;
  localparam logic [2:0] REG_ZENITH_DELTA  = 3'd3;
  localparam logic [2:0] REG_AZIMUTH_START = 3'd4;
  localparam logic [2:0] REG_AZIMUTH_DELTA = 3'd5;

  localparam int unsigned AtanCount = 24;
  localparam logic signed [34:0] CordicGain = 35'sd652032874;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41721;
      5'd15: v = 34'sd20860;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2607;
      5'd19: v = 34'sd1303;
      5'd20: v = 34'sd651;
      5'd21: v = 34'sd325;
      5'd22: v = 34'sd162;
      5'd23: v = 34'sd81;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/orbit_position_spherical_to_cartesian_top.sv =====
// ---------------------------------------------------------------------------
// orbit_position_spherical_to_cartesian_top
// Orbit camera eye position from interpolated radius, zenith and azimuth.
// ---------------------------------------------------------------------------
// Fully pipelined: one beat is accepted every cycle while the output is not
// stalled. The depth is set by the CORDIC rotators (one stage per iteration,
// zenith and azimuth side by side) plus two interpolation stages, the quadrant
// stage, three product stages and the output stage. All stages advance
// together and hold under output backpressure, so nothing is lost or repeated.
module orbit_position_spherical_to_cartesian_top #(
  parameter int ANGLE_BITS  = 16,
  parameter int TRIG_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ops2c_pkg::CfgIdxBits-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ops2c_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ops2c_pkg::out_t                     out_data
);

  localparam int Depth = TRIG_STAGES + 7;
  localparam int CsW = 35;

  logic signed [31:0] radius_start, radius_delta;
  logic [15:0]        zenith_start, azimuth_start;
  logic signed [23:0] zenith_delta, azimuth_delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_start  <= '0;
      radius_delta  <= '0;
      zenith_start  <= '0;
      zenith_delta  <= '0;
      azimuth_start <= '0;
      azimuth_delta <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ops2c_pkg::REG_RADIUS_START:  radius_start  <= cfg_data;
        ops2c_pkg::REG_RADIUS_DELTA:  radius_delta  <= cfg_data;
        ops2c_pkg::REG_ZENITH_START:  zenith_start  <= cfg_data[15:0];
        ops2c_pkg::REG_ZENITH_DELTA:  zenith_delta  <= cfg_data[23:0];
        ops2c_pkg::REG_AZIMUTH_START: azimuth_start <= cfg_data[15:0];
        ops2c_pkg::REG_AZIMUTH_DELTA: azimuth_delta <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic [Depth-1:0] vld;
  logic             adv;
  assign adv       = !vld[Depth-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // centres travel alongside
  logic signed [31:0] cxs [Depth-1];
  logic signed [31:0] cys [Depth-1];
  logic signed [31:0] czs [Depth-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      cxs[0] <= in_data.center_x;
      cys[0] <= in_data.center_y;
      czs[0] <= in_data.center_z;
      for (int k = 1; k < Depth - 1; k++) begin
        cxs[k] <= cxs[k-1];
        cys[k] <= cys[k-1];
        czs[k] <= czs[k-1];
      end
    end
  end

  // stage 1: clamp progress and take the three products
  logic [16:0] prog_c;
  assign prog_c = (in_data.progress > 17'd65536) ? 17'd65536 : in_data.progress;

  logic signed [49:0] rprod;
  logic [31:0]        zph1, aph1;
  always_ff @(posedge clk) begin
    if (adv) begin
      rprod <= 50'(radius_delta) * $signed({1'b0, prog_c});
      zph1  <= 32'(zenith_delta * $signed({1'b0, prog_c}));
      aph1  <= 32'(azimuth_delta * $signed({1'b0, prog_c}));
    end
  end

  // stage 2: radius, phase and quadrant reduction
  logic [31:0] amask;
  assign amask = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  logic [31:0] zph, aph, zq_add, aq_add;
  assign zph    = ({zenith_start, 16'd0} + zph1) & amask;
  assign aph    = ({azimuth_start, 16'd0} + aph1) & amask;
  assign zq_add = zph + 32'h2000_0000;
  assign aq_add = aph + 32'h2000_0000;

  logic signed [CsW-1:0] zx [TRIG_STAGES+1];
  logic signed [CsW-1:0] zy [TRIG_STAGES+1];
  logic signed [33:0]    zz [TRIG_STAGES+1];
  logic signed [CsW-1:0] ax [TRIG_STAGES+1];
  logic signed [CsW-1:0] ay [TRIG_STAGES+1];
  logic signed [33:0]    az [TRIG_STAGES+1];
  logic signed [33:0]    rr [TRIG_STAGES+1];
  logic [1:0]            zqs [TRIG_STAGES+1];
  logic [1:0]            aqs [TRIG_STAGES+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rr[0]  <= 34'(radius_start) + 34'(rprod >>> 16);
      zqs[0] <= zq_add[31:30];
      aqs[0] <= aq_add[31:30];
      zx[0]  <= ops2c_pkg::CordicGain;
      zy[0]  <= '0;
      zz[0]  <= 34'($signed(zph - {zq_add[31:30], 30'd0}));
      ax[0]  <= ops2c_pkg::CordicGain;
      ay[0]  <= '0;
      az[0]  <= 34'($signed(aph - {aq_add[31:30], 30'd0}));
    end
  end

  // CORDIC stages
  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cordic
    logic signed [33:0] at;
    assign at = (i < ops2c_pkg::AtanCount) ? ops2c_pkg::atan_turns(5'(i)) : 34'sd0;
    always_ff @(posedge clk) begin
      if (adv) begin
        rr[i+1]  <= rr[i];
        zqs[i+1] <= zqs[i];
        aqs[i+1] <= aqs[i];
        if (zz[i] >= 0) begin
          zx[i+1] <= zx[i] - (zy[i] >>> i);
          zy[i+1] <= zy[i] + (zx[i] >>> i);
          zz[i+1] <= zz[i] - at;
        end else begin
          zx[i+1] <= zx[i] + (zy[i] >>> i);
          zy[i+1] <= zy[i] - (zx[i] >>> i);
          zz[i+1] <= zz[i] + at;
        end
        if (az[i] >= 0) begin
          ax[i+1] <= ax[i] - (ay[i] >>> i);
          ay[i+1] <= ay[i] + (ax[i] >>> i);
          az[i+1] <= az[i] - at;
        end else begin
          ax[i+1] <= ax[i] + (ay[i] >>> i);
          ay[i+1] <= ay[i] - (ax[i] >>> i);
          az[i+1] <= az[i] + at;
        end
      end
    end
  end

  // quadrant rotation
  function automatic logic signed [CsW-1:0] quad_c(input logic [1:0] q,
      input logic signed [CsW-1:0] x, input logic signed [CsW-1:0] y);
    unique case (q)
      2'd0: return x;
      2'd1: return -y;
      2'd2: return -x;
      default: return y;
    endcase
  endfunction
  function automatic logic signed [CsW-1:0] quad_s(input logic [1:0] q,
      input logic signed [CsW-1:0] x, input logic signed [CsW-1:0] y);
    unique case (q)
      2'd0: return y;
      2'd1: return x;
      2'd2: return -y;
      default: return -x;
    endcase
  endfunction

  localparam int T = TRIG_STAGES;
  logic signed [CsW-1:0] cz_s, sz_s, ca_s, sa_s;
  logic signed [33:0]    r_s;
  always_ff @(posedge clk) begin
    if (adv) begin
      cz_s <= quad_c(zqs[T], zx[T], zy[T]);
      sz_s <= quad_s(zqs[T], zx[T], zy[T]);
      ca_s <= quad_c(aqs[T], ax[T], ay[T]);
      sa_s <= quad_s(aqs[T], ax[T], ay[T]);
      r_s  <= rr[T];
    end
  end

  // products
  logic signed [68:0] rsz, rcz;
  logic signed [CsW-1:0] ca_p, sa_p;
  always_ff @(posedge clk) begin
    if (adv) begin
      rsz  <= r_s * sz_s;
      rcz  <= r_s * cz_s;
      ca_p <= ca_s;
      sa_p <= sa_s;
    end
  end
  logic signed [38:0] t_v, zpart;
  assign t_v   = 39'(rsz >>> 30);
  logic signed [38:0] t_r, z_r;
  logic signed [CsW-1:0] ca_r, sa_r;
  assign zpart = 39'(rcz >>> 30);
  always_ff @(posedge clk) begin
    if (adv) begin
      t_r  <= t_v;
      z_r  <= zpart;
      ca_r <= ca_p;
      sa_r <= sa_p;
    end
  end
  logic signed [73:0] xp, yp;
  logic signed [38:0] z_r2;
  always_ff @(posedge clk) begin
    if (adv) begin
      xp   <= t_r * ca_r;
      yp   <= t_r * sa_r;
      z_r2 <= z_r;
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
    if (v > 45'sd2147483647)       return 32'sh7fff_ffff;
    else if (v < -45'sd2147483648) return 32'sh8000_0000;
    else                           return v[31:0];
  endfunction

  logic signed [44:0] ex, ey, ez;
  assign ex = 45'(cxs[Depth-2]) + 45'(xp >>> 30);
  assign ey = 45'(cys[Depth-2]) + 45'(yp >>> 30);
  assign ez = 45'(czs[Depth-2]) + 45'(z_r2);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.eye_x <= sat32(ex);
      out_data.eye_y <= sat32(ey);
      out_data.eye_z <= sat32(ez);
    end
  end

endmodule

// ===== src/ops2c_checker.sv =====
// ---------------------------------------------------------------------------
// ops2c_checker
// Port-level checks of the eye position converter.
// ---------------------------------------------------------------------------
`include "orbit_position_spherical_to_cartesian_top_macros.svh"

module ops2c_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input ops2c_pkg::out_t out_data
);

  // a waiting result stays put
  `OPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
  // the pipe frees up whenever the output drains
  `OPS_ASSERT_IMP(a_ready_when_drain, out_ready || !out_valid, in_ready, "input stalled with output free")
  // nothing comes out right after reset
  `OPS_ASSERT_IMP(a_reset_empty, $past(rst), !out_valid, "result beat right after reset")
  // a waiting input beat is not withdrawn
  `OPS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid, "input beat withdrawn while waiting")

endmodule

bind orbit_position_spherical_to_cartesian_top ops2c_checker u_ops2c_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/sv/tb_orbit_position_spherical_to_cartesian_top.sv =====
// ---------------------------------------------------------------------------
// tb_orbit_position_spherical_to_cartesian_top
// Drives progress and orbit-centre beats through the eye position converter
// under several register settings and random idling on both sides, and
// checks every eye beat against a CORDIC-based predictor kept in the bench.
// ---------------------------------------------------------------------------
module tb_orbit_position_spherical_to_cartesian_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AngBits = 16;
  localparam int TrigStages = 16;
  localparam int Latency = TrigStages + 7;
  localparam longint CycleLimit = 2000000;
  localparam logic [ops2c_pkg::CfgIdxBits-1:0] RegNone = 3'd7;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [ops2c_pkg::CfgIdxBits-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_ready;
  ops2c_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  ops2c_pkg::out_t out_data;

  orbit_position_spherical_to_cartesian_top #(
    .ANGLE_BITS(AngBits),
    .TRIG_STAGES(TrigStages)
  ) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  // register shadow
  logic signed [31:0] rad_start, rad_delta;
  logic [15:0] zen_start, azi_start;
  logic signed [23:0] zen_delta, azi_delta;

  ops2c_pkg::out_t eye_queue[$];
  int errors;
  longint cycles;

  typedef struct {
    logic [16:0] prog;
    logic [31:0] cx, cy, cz;
    bit known;
    ops2c_pkg::out_t eye;
  } row_t;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] phase_of(logic [15:0] st, logic signed [23:0] dl,
                                           longint prog);
    logic [31:0] p;
    longint d;
    d = dl;
    p = {st, 16'h0} + 32'(d * prog);
    return p & (32'hFFFFFFFF << (32 - AngBits));
  endfunction

  task automatic sin_cos(input logic [31:0] ph, output longint c, output longint s);
    logic [31:0] sum;
    logic [1:0] quad;
    logic [31:0] res;
    longint x, y, z, dx, dy;
    sum = ph + 32'h2000_0000;
    quad = sum[31:30];
    res = ph - {quad, 30'h0};
    z = longint'($signed(res));
    x = ops2c_pkg::CordicGain;
    y = 0;
    for (int i = 0; i < TrigStages && i < ops2c_pkg::AtanCount; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ops2c_pkg::atan_turns(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(ops2c_pkg::atan_turns(5'(i)));
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic eye_of(input ops2c_pkg::in_t b, output ops2c_pkg::out_t e);
    longint prog, r, t, cz_, sz, ca, sa;
    prog = b.progress;
    if (prog > 65536) prog = 65536;
    r = longint'(rad_start) + floor_sh(longint'(rad_delta) * prog, 16);
    sin_cos(phase_of(zen_start, zen_delta, prog), cz_, sz);
    sin_cos(phase_of(azi_start, azi_delta, prog), ca, sa);
    t = floor_sh(r * sz, 30);
    e.eye_x = 32'(clamp32(longint'(b.center_x) + floor_sh(t * ca, 30)));
    e.eye_y = 32'(clamp32(longint'(b.center_y) + floor_sh(t * sa, 30)));
    e.eye_z = 32'(clamp32(longint'(b.center_z) + floor_sh(r * cz_, 30)));
  endtask

  // the caller drops cfg_we after its last write
  task automatic write_reg(input logic [ops2c_pkg::CfgIdxBits-1:0] idx,
                           input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      ops2c_pkg::REG_RADIUS_START: rad_start = val;
      ops2c_pkg::REG_RADIUS_DELTA: rad_delta = val;
      ops2c_pkg::REG_ZENITH_START: zen_start = val[15:0];
      ops2c_pkg::REG_ZENITH_DELTA: zen_delta = val[23:0];
      ops2c_pkg::REG_AZIMUTH_START: azi_start = val[15:0];
      ops2c_pkg::REG_AZIMUTH_DELTA: azi_delta = val[23:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (eye_queue.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic set_all(input logic [31:0] rs, rd, zs, zd, as, ad);
    write_reg(ops2c_pkg::REG_RADIUS_START, rs);
    write_reg(ops2c_pkg::REG_RADIUS_DELTA, rd);
    write_reg(ops2c_pkg::REG_ZENITH_START, zs);
    write_reg(ops2c_pkg::REG_ZENITH_DELTA, zd);
    write_reg(ops2c_pkg::REG_AZIMUTH_START, as);
    write_reg(ops2c_pkg::REG_AZIMUTH_DELTA, ad);
    cfg_we <= 1'b0;
  endtask

  // in_valid stays high into the next beat when there is no gap
  task automatic send(input ops2c_pkg::in_t b, input bit known,
                      input ops2c_pkg::out_t given);
    ops2c_pkg::out_t e;
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    eye_of(b, e);
    if (known && e != given) begin
      errors++;
      if (errors <= 10)
        $display("table row disagrees with predictor: exp %h got %h", given, e);
    end
    in_valid <= 1'b1;
    in_data <= b;
    eye_queue.push_back(e);
    do @(posedge clk); while (!in_ready);
  endtask

  // sink with random stalls
  int stall;
  always @(posedge clk) begin
    ops2c_pkg::out_t e;
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (eye_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("eye beat with nothing expected: %h", out_data);
        end else begin
          e = eye_queue.pop_front();
          if (out_data.eye_x !== e.eye_x || out_data.eye_y !== e.eye_y ||
              out_data.eye_z !== e.eye_z) begin
            errors++;
            if (errors <= 10)
              $display("eye mismatch: exp %h %h %h got %h %h %h", e.eye_x, e.eye_y,
                       e.eye_z, out_data.eye_x, out_data.eye_y, out_data.eye_z);
          end
        end
      end
      w = $urandom_range(0, 13);
      if ($urandom_range(0, 1) == 0) w = 0;
      if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && w > 0) begin
        out_ready <= 1'b0;
        stall <= w - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic ops2c_pkg::in_t rand_beat();
    ops2c_pkg::in_t b;
    case ($urandom_range(0, 5))
      0: b.progress = 17'd65536;
      1: b.progress = 17'($urandom_range(65537, 131071));
      2: b.progress = 17'd0;
      default: b.progress = 17'($urandom_range(0, 65536));
    endcase
    b.center_x = $urandom;
    b.center_y = $urandom;
    b.center_z = $urandom;
    if ($urandom_range(0, 1)) begin
      b.center_x = $signed(b.center_x) >>> 10;
      b.center_y = $signed(b.center_y) >>> 10;
      b.center_z = $signed(b.center_z) >>> 10;
    end
    return b;
  endfunction

  row_t rows[$];
  ops2c_pkg::out_t none;

  initial begin
    ops2c_pkg::in_t b;
    row_t rw;
    errors = 0;
    cycles = 0;
    none = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    rad_start = 0; rad_delta = 0; zen_start = 0; zen_delta = 0;
    azi_start = 0; azi_delta = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset radius is zero: eye equals the centre
    rows.push_back('{17'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 1,
                     '{32'h7FFFFFFF, 32'h80000000, 32'h00010000}});
    rows.push_back('{17'h1FFFF, 32'h0, 32'hFFFFFFFF, 32'h12345678, 1,
                     '{32'h0, 32'hFFFFFFFF, 32'h12345678}});
    foreach (rows[i]) begin
      b.progress = rows[i].prog;
      b.center_x = rows[i].cx; b.center_y = rows[i].cy; b.center_z = rows[i].cz;
      send(b, rows[i].known, rows[i].eye);
    end
    drain();

    // extreme registers: saturation, wide radius, negative radius, wrap
    set_all(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0000FFFF, 32'h007FFFFF,
            32'h0000FFFF, 32'h00800000);
    rows.delete();
    rows.push_back('{17'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, none});
    rows.push_back('{17'd65536, 32'h80000000, 32'h80000000, 32'h80000000, 0, none});
    rows.push_back('{17'h1FFFF, 32'h0, 32'h0, 32'h0, 0, none});
    rows.push_back('{17'd32768, 32'h0, 32'h0, 32'h0, 0, none});
    rows.push_back('{17'd1, 32'h1, 32'hFFFFFFFF, 32'h0, 0, none});
    foreach (rows[i]) begin
      b.progress = rows[i].prog;
      b.center_x = rows[i].cx; b.center_y = rows[i].cy; b.center_z = rows[i].cz;
      send(b, 0, none);
    end
    drain();
    set_all(32'h80000000, 32'h80000000, 32'h0, 32'h00800000, 32'h0, 32'h007FFFFF);
    write_reg(RegNone, 32'hFFFFFFFF);  // unknown index is ignored
    cfg_we <= 1'b0;
    foreach (rows[i]) begin
      b.progress = rows[i].prog;
      b.center_x = rows[i].cx; b.center_y = rows[i].cy; b.center_z = rows[i].cz;
      send(b, 0, none);
    end
    // zenith on exact quarter turns, azimuth half-way between them
    for (int q = 0; q < 4; q++) begin
      drain();
      set_all(32'h00010000, 32'h0, 32'(q * 16384), 32'h0, 32'(q * 16384 + 8192), 32'h0);
      b = rand_beat();
      send(b, 0, none);
    end
    drain();

    // random phases with random settings
    for (int ph = 0; ph < 12; ph++) begin
      set_all($urandom >> $urandom_range(0, 16), $urandom >> $urandom_range(0, 16),
              $urandom, $urandom, $urandom, $urandom);
      for (int n = 0; n < 152; n++) send(rand_beat(), 0, none);
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
